// File: hdl/cmrm_pkg.sv
// Package: shared types, constants and the merge micro-op table for the costmap fuser.
`default_nettype none
package cmrm_pkg;

    // Global grid geometry.
    localparam int MAP_WIDTH  = 300;
    localparam int MAP_HEIGHT = 300;
    localparam int GRID_CELLS = MAP_WIDTH * MAP_HEIGHT;
    localparam int ADDR_W     = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
    localparam int IDX_W      = 20;   // holds row*width+col for any legal geometry
    localparam int OIDX_W     = 17;
    localparam int VAL_W      = 7;
    localparam int COORD_W    = 10;
    localparam int LOC_W      = 44;   // local point, Q.17
    localparam int LO_W       = 22;   // low slice fed to the multiplier
    localparam int OPA_W      = 23;
    localparam int OPB_W      = 17;
    localparam int PROD_W     = OPA_W + OPB_W;
    localparam int ACC_W      = 64;

    // World coordinate bounds in Q.31: in-bounds means -1 < w < size.
    localparam logic signed [ACC_W-1:0] NEG_LIM = -(64'sd1 <<< 31);
    localparam logic signed [ACC_W-1:0] X_LIM   = 64'(MAP_WIDTH) << 31;
    localparam logic signed [ACC_W-1:0] Y_LIM   = 64'(MAP_HEIGHT) << 31;

    // Register reset values.
    localparam logic [30:0]        RST_CELL_SIZE = 31'd65536;
    localparam logic signed [31:0] RST_ORIGIN    = 32'sd0;
    localparam logic signed [31:0] RST_POSE      = 32'sd9830400;
    localparam logic signed [15:0] RST_COS       = 16'sd16384;
    localparam logic signed [15:0] RST_SIN       = 16'sd0;

    localparam logic MODE_MERGE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef enum logic [2:0] {
        CFG_CELL_SIZE = 3'd0,
        CFG_ORIGIN_X  = 3'd1,
        CFG_ORIGIN_Y  = 3'd2,
        CFG_POSE_X    = 3'd3,
        CFG_POSE_Y    = 3'd4,
        CFG_COS       = 3'd5,
        CFG_SIN       = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        A_SIZE_LO, A_SIZE_HI, A_LX_LO, A_LX_HI, A_LY_LO, A_LY_HI
    } t_asel;

    typedef enum logic [1:0] {B_COL, B_ROW, B_COS, B_SIN} t_bsel;

    typedef enum logic [1:0] {BASE_OX, BASE_OY, BASE_PX, BASE_PY} t_base;

    typedef enum logic [2:0] {DST_LX, DST_LY, DST_WX, DST_WY, DST_IDX} t_dst;

    typedef struct packed {
        t_asel asel;
        t_bsel bsel;
        logic  sh;      // weight product by 2^LO_W
        logic  neg;     // subtract
        logic  first;   // start a new sum from the base
        logic  last;    // sum complete
        t_base base;
        t_dst  dst;
    } t_uop;

    // Request to the shared multiply-accumulate unit.
    typedef struct packed {
        logic                    valid;
        logic signed [OPA_W-1:0] a;
        logic signed [OPB_W-1:0] b;
        logic                    sh;
        logic                    neg;
        logic                    first;
        logic                    last;
        logic signed [ACC_W-1:0] base;
        t_dst                    dst;
    } t_mac_req;

    typedef struct packed {
        logic                    valid;
        t_dst                    dst;
        logic signed [ACC_W-1:0] value;
    } t_mac_res;

    localparam int NUM_STEPS = 12;
    localparam int STEP_W    = 4;

    // Merge sequence: local point x, y, then rotated world x, y.
    function automatic t_uop uop_at(input logic [STEP_W-1:0] step);
        t_uop u;
        case (step)
            4'd0:    u = '{A_SIZE_LO, B_COL, 1'b0, 1'b0, 1'b1, 1'b0, BASE_OX, DST_LX};
            4'd1:    u = '{A_SIZE_HI, B_COL, 1'b1, 1'b0, 1'b0, 1'b1, BASE_OX, DST_LX};
            4'd2:    u = '{A_SIZE_LO, B_ROW, 1'b0, 1'b0, 1'b1, 1'b0, BASE_OY, DST_LY};
            4'd3:    u = '{A_SIZE_HI, B_ROW, 1'b1, 1'b0, 1'b0, 1'b1, BASE_OY, DST_LY};
            4'd4:    u = '{A_LX_LO,   B_COS, 1'b0, 1'b0, 1'b1, 1'b0, BASE_PX, DST_WX};
            4'd5:    u = '{A_LX_HI,   B_COS, 1'b1, 1'b0, 1'b0, 1'b0, BASE_PX, DST_WX};
            4'd6:    u = '{A_LY_LO,   B_SIN, 1'b0, 1'b1, 1'b0, 1'b0, BASE_PX, DST_WX};
            4'd7:    u = '{A_LY_HI,   B_SIN, 1'b1, 1'b1, 1'b0, 1'b1, BASE_PX, DST_WX};
            4'd8:    u = '{A_LX_LO,   B_SIN, 1'b0, 1'b0, 1'b1, 1'b0, BASE_PY, DST_WY};
            4'd9:    u = '{A_LX_HI,   B_SIN, 1'b1, 1'b0, 1'b0, 1'b0, BASE_PY, DST_WY};
            4'd10:   u = '{A_LY_LO,   B_COS, 1'b0, 1'b0, 1'b0, 1'b0, BASE_PY, DST_WY};
            4'd11:   u = '{A_LY_HI,   B_COS, 1'b1, 1'b0, 1'b0, 1'b1, BASE_PY, DST_WY};
            default: u = '{A_SIZE_LO, B_COL, 1'b0, 1'b0, 1'b0, 1'b0, BASE_OX, DST_LX};
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

// File: hdl/costmap_rotate_merge_max_top.sv
// Top level: config registers, merge sequencer, grid read-modify-write and result register.
//
// Costmap fuser. Merges local costmap cells into a stored 300x300 grid of 7-bit costs
// (keep the larger) and reads stored cells back.
// Channels:
//   input beat  : i_in_valid / o_in_stall, fields i_mode, i_cell_col, i_cell_row, i_cost,
//                 i_read_col, i_read_row. Taken when valid is high and stall is low.
//   result beat : o_out_valid / i_out_stall, one result per input beat, in order.
//   config      : i_cfg_valid / o_cfg_ready (always ready), i_cfg_index, i_cfg_data.
//                 Write only while the block is idle; unknown indexes are ignored.
// Timing: one item at a time. A merge runs all the products described below, a read only
//   the index product; an out-of-bounds item skips the grid access, and a skipped merge
//   goes straight to its result. The next beat can be taken in the cycle the result shows.
//   Work is paced by the shared 23x17 multiply-accumulate unit, which runs twelve
//   products per merge (local point plus rotation), then one for the row*width index,
//   followed by the single-port grid read-modify-write.
// Reset: registers take their reset values and the grid is cleared one cell a cycle,
//   all 90000 cells, while o_in_stall stays high (config writes still taken).
// Stall: a finished result waits in the output register; the next beat is accepted
//   meanwhile and the sequencer holds its own result until the output register frees.
`default_nettype none
module costmap_rotate_merge_max_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [9:0]                    i_cell_col,
    input  logic [9:0]                    i_cell_row,
    input  logic signed [7:0]             i_cost,
    input  logic [8:0]                    i_read_col,
    input  logic [8:0]                    i_read_row,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_written,
    output logic                          o_skipped,
    output logic                          o_out_of_bounds,
    output logic [cmrm_pkg::OIDX_W-1:0]   o_map_index,
    output logic [cmrm_pkg::VAL_W-1:0]    o_cell_value,
    // config write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [2:0]                    i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);
    import cmrm_pkg::*;

    typedef enum logic [9:0] {
        S_CLEAR    = 10'b0000000001,
        S_IDLE     = 10'b0000000010,
        S_MAC      = 10'b0000000100,
        S_WAIT_WY  = 10'b0000001000,
        S_CHECK    = 10'b0000010000,
        S_INDEX    = 10'b0000100000,
        S_WAIT_IDX = 10'b0001000000,
        S_RDMEM    = 10'b0010000000,
        S_MERGE    = 10'b0100000000,
        S_DONE     = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    // config
    logic [30:0]        r_size;
    logic signed [31:0] r_ox, r_oy, r_px, r_py;
    logic signed [15:0] r_cos, r_sin;

    // item and working values
    logic                     r_mode;
    logic [COORD_W-1:0]       r_col, r_row;
    logic [VAL_W-1:0]         r_cost;
    logic [STEP_W-1:0]        r_step;
    logic signed [LOC_W-1:0]  r_lx, r_ly;
    logic signed [ACC_W-1:0]  r_wx, r_wy;
    logic [COORD_W-1:0]       r_gx, r_gy;
    logic                     r_ok;
    logic [IDX_W-1:0]         r_idx;
    logic [ADDR_W-1:0]        r_clr_addr;

    // pending result and output register
    logic                r_res_written, r_res_skipped, r_res_oob;
    logic [OIDX_W-1:0]   r_res_idx;
    logic [VAL_W-1:0]    r_res_val;
    logic                r_out_valid;
    logic                r_out_written, r_out_skipped, r_out_oob;
    logic [OIDX_W-1:0]   r_out_idx;
    logic [VAL_W-1:0]    r_out_val;

    t_uop             w_uop;
    t_mac_req         w_req;
    t_mac_res         w_res;
    logic             w_in_acc;
    logic             w_out_free;
    logic             w_skip;
    logic             w_ok_x, w_ok_y;
    logic             w_we, w_re;
    logic [ADDR_W-1:0] w_addr;
    logic [VAL_W-1:0]  w_wdata;
    logic [VAL_W-1:0]  w_rdata;
    logic              w_bigger;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_skip      = i_cost[7] || (i_cost == 8'sd0);
    assign w_ok_x      = (r_wx > NEG_LIM) && (r_wx < X_LIM);
    assign w_ok_y      = (r_wy > NEG_LIM) && (r_wy < Y_LIM);
    assign w_bigger    = (r_cost > w_rdata);

    // operand selection for the shared multiply-accumulate unit
    always_comb begin
        w_uop       = uop_at(r_step);
        w_req.valid = (r_state == S_MAC);
        w_req.sh    = w_uop.sh;
        w_req.neg   = w_uop.neg;
        w_req.first = w_uop.first;
        w_req.last  = w_uop.last;
        w_req.dst   = w_uop.dst;
        case (w_uop.asel)
            A_SIZE_LO: w_req.a = {1'b0, r_size[LO_W-1:0]};
            A_SIZE_HI: w_req.a = OPA_W'(r_size[30:LO_W]);
            A_LX_LO:   w_req.a = {1'b0, r_lx[LO_W-1:0]};
            A_LX_HI:   w_req.a = {r_lx[LOC_W-1], r_lx[LOC_W-1:LO_W]};
            A_LY_LO:   w_req.a = {1'b0, r_ly[LO_W-1:0]};
            A_LY_HI:   w_req.a = {r_ly[LOC_W-1], r_ly[LOC_W-1:LO_W]};
            default:   w_req.a = '0;
        endcase
        case (w_uop.bsel)
            B_COL:   w_req.b = OPB_W'({r_col, 1'b1});
            B_ROW:   w_req.b = OPB_W'({r_row, 1'b1});
            B_COS:   w_req.b = {r_cos[15], r_cos};
            default: w_req.b = {r_sin[15], r_sin};
        endcase
        case (w_uop.base)
            BASE_OX: w_req.base = ACC_W'(r_ox) <<< 1;
            BASE_OY: w_req.base = ACC_W'(r_oy) <<< 1;
            BASE_PX: w_req.base = ACC_W'(r_px) <<< 15;
            default: w_req.base = ACC_W'(r_py) <<< 15;
        endcase
        // index = row * width + col in one pass
        if (r_state == S_INDEX) begin
            w_req.valid = r_ok;
            w_req.a     = OPA_W'(r_gy);
            w_req.b     = OPB_W'(MAP_WIDTH);
            w_req.sh    = 1'b0;
            w_req.neg   = 1'b0;
            w_req.first = 1'b1;
            w_req.last  = 1'b1;
            w_req.base  = ACC_W'(r_gx);
            w_req.dst   = DST_IDX;
        end
    end

    cmrm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_res   (w_res)
    );

    // grid port
    always_comb begin
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_addr  = r_idx[ADDR_W-1:0];
        w_wdata = r_cost;
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_addr  = r_clr_addr;
            w_wdata = '0;
        end else if (r_state == S_RDMEM) begin
            w_re = 1'b1;
        end else if (r_state == S_MERGE) begin
            w_we = (r_mode == MODE_MERGE) && w_bigger;
        end
    end

    cmrm_grid u_grid (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_re    (w_re),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == ADDR_W'(GRID_CELLS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_mode == MODE_READ) n_state = S_INDEX;
                    else if (w_skip)         n_state = S_DONE;
                    else                     n_state = S_MAC;
                end
            end
            S_MAC: begin
                if (r_step == STEP_W'(NUM_STEPS - 1)) n_state = S_WAIT_WY;
            end
            S_WAIT_WY: begin
                if (w_res.valid && (w_res.dst == DST_WY)) n_state = S_CHECK;
            end
            S_CHECK: n_state = S_INDEX;
            S_INDEX: n_state = r_ok ? S_WAIT_IDX : S_DONE;
            S_WAIT_IDX: begin
                if (w_res.valid && (w_res.dst == DST_IDX)) n_state = S_RDMEM;
            end
            S_RDMEM: n_state = S_MERGE;
            S_MERGE: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_size      <= RST_CELL_SIZE;
            r_ox        <= RST_ORIGIN;
            r_oy        <= RST_ORIGIN;
            r_px        <= RST_POSE;
            r_py        <= RST_POSE;
            r_cos       <= RST_COS;
            r_sin       <= RST_SIN;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == S_MAC) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_CELL_SIZE: r_size <= i_cfg_data[30:0];
                    CFG_ORIGIN_X:  r_ox   <= i_cfg_data;
                    CFG_ORIGIN_Y:  r_oy   <= i_cfg_data;
                    CFG_POSE_X:    r_px   <= i_cfg_data;
                    CFG_POSE_Y:    r_py   <= i_cfg_data;
                    CFG_COS:       r_cos  <= i_cfg_data[15:0];
                    CFG_SIN:       r_sin  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end

        // payload; a read never counts as skipped, whatever its cost field holds
        if (w_in_acc) begin
            r_mode <= i_mode;
            r_col  <= i_cell_col;
            r_row  <= i_cell_row;
            r_cost <= i_cost[VAL_W-1:0];
            r_gx   <= COORD_W'(i_read_col);
            r_gy   <= COORD_W'(i_read_row);
            r_ok   <= (11'(i_read_col) < 11'(MAP_WIDTH)) && (11'(i_read_row) < 11'(MAP_HEIGHT));
            r_res_written <= 1'b0;
            r_res_skipped <= (i_mode == MODE_MERGE) && w_skip;
            r_res_oob     <= 1'b0;
            r_res_idx     <= '0;
            r_res_val     <= '0;
        end

        if (w_res.valid) begin
            case (w_res.dst)
                DST_LX:  r_lx  <= w_res.value[LOC_W-1:0];
                DST_LY:  r_ly  <= w_res.value[LOC_W-1:0];
                DST_WX:  r_wx  <= w_res.value;
                DST_WY:  r_wy  <= w_res.value;
                DST_IDX: r_idx <= w_res.value[IDX_W-1:0];
                default: ;
            endcase
        end

        // truncate toward zero; anything in (-1, 0) lands in cell 0
        if (r_state == S_CHECK) begin
            r_ok <= w_ok_x && w_ok_y;
            r_gx <= r_wx[ACC_W-1] ? '0 : r_wx[31 +: COORD_W];
            r_gy <= r_wy[ACC_W-1] ? '0 : r_wy[31 +: COORD_W];
        end

        if (r_state == S_INDEX && !r_ok) begin
            r_res_oob <= 1'b1;
        end

        if (r_state == S_MERGE) begin
            r_res_written <= (r_mode == MODE_MERGE);
            r_res_idx     <= r_idx[OIDX_W-1:0];
            r_res_val     <= ((r_mode == MODE_MERGE) && w_bigger) ? r_cost : w_rdata;
        end

        if (r_state == S_DONE && w_out_free) begin
            r_out_written <= r_res_written;
            r_out_skipped <= r_res_skipped;
            r_out_oob     <= r_res_oob;
            r_out_idx     <= r_res_idx;
            r_out_val     <= r_res_val;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_written       = r_out_written;
    assign o_skipped       = r_out_skipped;
    assign o_out_of_bounds = r_out_oob;
    assign o_map_index     = r_out_idx;
    assign o_cell_value    = r_out_val;

`ifndef SYNTH
    // grid is only written by the clearing pass or a merge update
    a_grid_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_CLEAR) || (r_state == S_MERGE))
        else $error("grid written outside clear or merge");

    // finished sums only come back while the sequencer expects them
    a_mac_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> (r_state == S_MAC) || (r_state == S_WAIT_WY) ||
                        (r_state == S_WAIT_IDX))
        else $error("accumulator result outside a compute state");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_written, o_skipped, o_out_of_bounds}))
        else $error("conflicting result flags");

    a_empty_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_skipped || o_out_of_bounds)) |->
            (o_map_index == '0) && (o_cell_value == '0))
        else $error("skipped or out-of-bounds result carries data");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("accepted beat did not start work");
`endif

endmodule
`default_nettype wire

// File: hdl/cmrm_mac.sv
// Shared multiply-accumulate unit: registered 23x17 product, then 64-bit accumulate.
`default_nettype none
module cmrm_mac (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cmrm_pkg::t_mac_req i_req,
    output cmrm_pkg::t_mac_res o_res
);
    import cmrm_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_p_valid;
    logic                     r_p_sh;
    logic                     r_p_neg;
    logic                     r_p_first;
    logic                     r_p_last;
    logic signed [ACC_W-1:0]  r_p_base;
    t_dst                     r_p_dst;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_res_valid;
    t_dst                     r_res_dst;

    logic signed [ACC_W-1:0]  w_ext;
    logic signed [ACC_W-1:0]  w_term;
    logic signed [ACC_W-1:0]  n_acc;

    always_comb begin
        w_ext  = ACC_W'(r_prod);
        w_term = r_p_sh ? (w_ext <<< LO_W) : w_ext;
        if (r_p_neg) begin
            w_term = -w_term;
        end
        n_acc = (r_p_first ? r_p_base : r_acc) + w_term;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid   <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_p_valid   <= i_req.valid;
            r_res_valid <= r_p_valid && r_p_last;
        end
        r_prod    <= i_req.a * i_req.b;
        r_p_sh    <= i_req.sh;
        r_p_neg   <= i_req.neg;
        r_p_first <= i_req.first;
        r_p_last  <= i_req.last;
        r_p_base  <= i_req.base;
        r_p_dst   <= i_req.dst;
        if (r_p_valid) begin
            r_acc     <= n_acc;
            r_res_dst <= r_p_dst;
        end
    end

    assign o_res.valid = r_res_valid;
    assign o_res.dst   = r_res_dst;
    assign o_res.value = r_acc;

endmodule
`default_nettype wire

// File: hdl/cmrm_grid.sv
// Global grid store: single-port memory with registered read data.
`default_nettype none
module cmrm_grid (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic                       i_re,
    input  logic [cmrm_pkg::ADDR_W-1:0] i_addr,
    input  logic [cmrm_pkg::VAL_W-1:0]  i_wdata,
    output logic [cmrm_pkg::VAL_W-1:0]  o_rdata
);
    import cmrm_pkg::*;

    logic [VAL_W-1:0] r_mem [GRID_CELLS];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: sim/testbench.sv
// Self-checking bench for the costmap fuser: directed table, then random beats against a model.
module testbench;
    import cmrm_pkg::*;

    localparam int LIMIT_CYCLES       = 1_000_000;
    localparam int SETTLE_CYCLES      = 30;
    localparam int RANDOM_PHASE_BEATS = 250;
    localparam logic [2:0] CFG_SPARE  = 3'd7; // unmapped register index

    typedef struct packed {
        logic              written;
        logic              skipped;
        logic              oob;
        logic [OIDX_W-1:0] idx;
        logic [VAL_W-1:0]  val;
    } cell_result_t;

    typedef struct {
        logic              mode;
        logic [9:0]        col;
        logic [9:0]        row;
        logic signed [7:0] cost;
        logic [8:0]        rcol;
        logic [8:0]        rrow;
    } cell_item_t;

    typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t    kind;
        cell_item_t   beat;
        logic         typed;
        cell_result_t want;
        logic [2:0]   reg_idx;
        logic [31:0]  reg_data;
    } plan_row_t;

    localparam cell_result_t RES_SKIP = '{1'b0, 1'b1, 1'b0, 17'd0, 7'd0};
    localparam cell_result_t RES_OOB  = '{1'b0, 1'b0, 1'b1, 17'd0, 7'd0};

    // DUT ports
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    logic               i_mode      = MODE_MERGE;
    logic [9:0]         i_cell_col  = '0;
    logic [9:0]         i_cell_row  = '0;
    logic signed [7:0]  i_cost      = '0;
    logic [8:0]         i_read_col  = '0;
    logic [8:0]         i_read_row  = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_written;
    logic               o_skipped;
    logic               o_out_of_bounds;
    logic [OIDX_W-1:0]  o_map_index;
    logic [VAL_W-1:0]   o_cell_value;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data  = '0;

    // Model of the grid and the registers
    logic [VAL_W-1:0] grid_model [GRID_CELLS];
    longint reg_size = longint'(RST_CELL_SIZE);
    longint reg_ox   = RST_ORIGIN;
    longint reg_oy   = RST_ORIGIN;
    longint reg_px   = RST_POSE;
    longint reg_py   = RST_POSE;
    longint reg_cos  = RST_COS;
    longint reg_sin  = RST_SIN;

    cell_result_t cell_results_due [$];
    int           hit_cells [$];      // recently written cells, for read-back
    plan_row_t    plan [$];
    int           mismatches     = 0;
    int           send_idle_pct  = 12;
    int           recv_stall_pct = 88;
    int           cycle_cnt      = 0;

    costmap_rotate_merge_max_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_cell_col     (i_cell_col),
        .i_cell_row     (i_cell_row),
        .i_cost         (i_cost),
        .i_read_col     (i_read_col),
        .i_read_row     (i_read_row),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_written      (o_written),
        .o_skipped      (o_skipped),
        .o_out_of_bounds(o_out_of_bounds),
        .o_map_index    (o_map_index),
        .o_cell_value   (o_cell_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            CFG_CELL_SIZE: reg_size = longint'(data[30:0]);
            CFG_ORIGIN_X:  reg_ox   = longint'(signed'(data));
            CFG_ORIGIN_Y:  reg_oy   = longint'(signed'(data));
            CFG_POSE_X:    reg_px   = longint'(signed'(data));
            CFG_POSE_Y:    reg_py   = longint'(signed'(data));
            CFG_COS:       reg_cos  = longint'(signed'(data[15:0]));
            CFG_SIN:       reg_sin  = longint'(signed'(data[15:0]));
            default: ;
        endcase
    endfunction

    // Q.31 world coordinate truncated toward zero
    function automatic longint world_to_cell(input longint v);
        if (v < 0)
            return -((-v) >>> 31);
        return v >>> 31;
    endfunction

    // Expected result of one beat; updates the grid model on a merge hit.
    function automatic cell_result_t fuse_cell(input cell_item_t it);
        cell_result_t r;
        longint lx, ly, wx, wy, gx, gy;
        int idx;
        r = '0;
        if (it.mode == MODE_READ) begin
            if (it.rcol >= MAP_WIDTH || it.rrow >= MAP_HEIGHT) begin
                r.oob = 1'b1;
            end else begin
                idx = int'(it.rrow) * MAP_WIDTH + int'(it.rcol);
                r.idx = OIDX_W'(idx);
                r.val = grid_model[idx];
            end
            return r;
        end
        if (it.cost <= 0) begin
            r.skipped = 1'b1;
            return r;
        end
        // cell centre in Q.17, rotation to Q.31, pose lifted to Q.31
        lx = (2 * longint'(it.col) + 1) * reg_size + 2 * reg_ox;
        ly = (2 * longint'(it.row) + 1) * reg_size + 2 * reg_oy;
        wx = reg_px * 32768 + (lx * reg_cos - ly * reg_sin);
        wy = reg_py * 32768 + (lx * reg_sin + ly * reg_cos);
        gx = world_to_cell(wx);
        gy = world_to_cell(wy);
        if (gx < 0 || gx >= MAP_WIDTH || gy < 0 || gy >= MAP_HEIGHT) begin
            r.oob = 1'b1;
            return r;
        end
        idx = int'(gy) * MAP_WIDTH + int'(gx);
        if (it.cost[6:0] > grid_model[idx])
            grid_model[idx] = it.cost[6:0];
        r.written = 1'b1;
        r.idx     = OIDX_W'(idx);
        r.val     = grid_model[idx];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [16:0] want,
                               input logic [16:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result side: compare each accepted beat with the oldest pending expectation.
    always @(posedge i_clk) begin
        cell_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (cell_results_due.size() == 0) begin
                $display("%0t: unexpected result, got w=%0b s=%0b oob=%0b idx=%0d val=%0d",
                         $time, o_written, o_skipped, o_out_of_bounds, o_map_index,
                         o_cell_value);
                mismatches++;
            end else begin
                want = cell_results_due.pop_front();
                check_field("written", want.written, o_written);
                check_field("skipped", want.skipped, o_skipped);
                check_field("out_of_bounds", want.oob, o_out_of_bounds);
                check_field("map_index", want.idx, o_map_index);
                check_field("cell_value", want.val, o_cell_value);
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    initial begin
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("%0t: timeout", $time);
        $display("costmap_rotate_merge_max_top test failed");
        $finish;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Present one beat and hold it until taken; valid stays high afterwards.
    task automatic send_item(input cell_item_t it, input logic typed,
                             input cell_result_t want);
        cell_result_t r;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_mode     <= it.mode;
        i_cell_col <= it.col;
        i_cell_row <= it.row;
        i_cost     <= it.cost;
        i_read_col <= it.rcol;
        i_read_row <= it.rrow;
        do @(posedge i_clk); while (o_in_stall);
        r = fuse_cell(it);
        if (r.written)
            hit_cells.push_back(int'(r.idx));
        if (hit_cells.size() > 64)
            void'(hit_cells.pop_front());
        cell_results_due.push_back(typed ? want : r);
    endtask

    task automatic sender_gap();
        if ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
        end
    endtask

    // Stop sending and let every pending result come out.
    task automatic settle_block();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (cell_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly a plausible pose and scale so merges land; wild picks full-range values.
    task automatic load_setting(input logic wild);
        logic [31:0] data;
        logic        pick;
        int          trig;
        for (int i = 0; i <= CFG_SIN; i++) begin
            pick = wild && ($urandom_range(0, 3) == 0);
            trig = int'($urandom_range(0, 32768)) - 16384;
            if (pick && $urandom_range(0, 1) == 1)
                trig = ($urandom_range(0, 1) == 1) ? 16384 : -16384;
            case (i)
                CFG_CELL_SIZE: data = pick ? $urandom() : $urandom_range(16384, 131072);
                CFG_ORIGIN_X, CFG_ORIGIN_Y:
                    data = pick ? $urandom() : 32'(int'($urandom_range(0, 1310720)) - 655360);
                CFG_POSE_X, CFG_POSE_Y:
                    data = pick ? $urandom() : $urandom_range(0, MAP_WIDTH * 65536);
                default: data = pick ? {16'($urandom_range(0, 65535)), 16'(trig)} : 32'(trig);
            endcase
            write_reg(3'(i), data);
        end
        if ($urandom_range(0, 1) == 1)
            write_reg(CFG_SPARE, $urandom());
    endtask

    function automatic cell_item_t random_beat();
        cell_item_t it;
        int idx;
        it.mode = ($urandom_range(0, 99) < 30) ? MODE_READ : MODE_MERGE;
        it.col  = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, 255))
                                             : 10'($urandom_range(0, 1023));
        it.row  = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, 255))
                                             : 10'($urandom_range(0, 1023));
        it.cost = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(1, 127))
                                             : 8'($urandom_range(0, 255));
        it.rcol = 9'($urandom_range(0, 511));
        it.rrow = 9'($urandom_range(0, 511));
        if (it.mode == MODE_READ) begin
            if (hit_cells.size() != 0 && $urandom_range(0, 1) == 1) begin
                idx     = hit_cells[$urandom_range(0, hit_cells.size() - 1)];
                it.rcol = 9'(idx % MAP_WIDTH);
                it.rrow = 9'(idx / MAP_WIDTH);
            end else if ($urandom_range(0, 4) != 0) begin
                it.rcol = 9'($urandom_range(0, MAP_WIDTH - 1));
                it.rrow = 9'($urandom_range(0, MAP_HEIGHT - 1));
            end
        end
        return it;
    endfunction

    function automatic plan_row_t beat_row(input logic mode, input int col, input int row,
                                           input int cost, input int rc, input int rr,
                                           input logic typed, input cell_result_t want);
        plan_row_t p;
        p.kind      = ROW_BEAT;
        p.beat.mode = mode;
        p.beat.col  = 10'(col);
        p.beat.row  = 10'(row);
        p.beat.cost = 8'(cost);
        p.beat.rcol = 9'(rc);
        p.beat.rrow = 9'(rr);
        p.typed     = typed;
        p.want      = want;
        p.reg_idx   = '0;
        p.reg_data  = '0;
        return p;
    endfunction

    function automatic plan_row_t reg_row(input logic [2:0] idx, input logic [31:0] data);
        plan_row_t p;
        p = beat_row(MODE_MERGE, 0, 0, 0, 0, 0, 1'b0, '0);
        p.kind     = ROW_REG;
        p.reg_idx  = idx;
        p.reg_data = data;
        return p;
    endfunction

    initial begin
        cell_item_t it;
        foreach (grid_model[i]) grid_model[i] = '0;

        // Reset pose: cell (c, r) lands on global (150 + c, 150 + r).
        plan.push_back(beat_row(MODE_READ, 0, 0, 0, 0, 0, 1'b1, '0));
        plan.push_back(beat_row(MODE_READ, 0, 0, 0, 299, 299, 1'b1,
                                '{1'b0, 1'b0, 1'b0, 17'd89999, 7'd0}));
        plan.push_back(beat_row(MODE_READ, 0, 0, 0, 300, 0, 1'b1, RES_OOB));
        plan.push_back(beat_row(MODE_READ, 0, 0, 0, 511, 511, 1'b1, RES_OOB));
        plan.push_back(beat_row(MODE_MERGE, 0, 0, 127, 0, 0, 1'b1,
                                '{1'b1, 1'b0, 1'b0, 17'd45150, 7'd127}));
        // lower cost keeps the stored maximum
        plan.push_back(beat_row(MODE_MERGE, 0, 0, 5, 0, 0, 1'b1,
                                '{1'b1, 1'b0, 1'b0, 17'd45150, 7'd127}));
        plan.push_back(beat_row(MODE_READ, 0, 0, 0, 150, 150, 1'b1,
                                '{1'b0, 1'b0, 1'b0, 17'd45150, 7'd127}));
        plan.push_back(beat_row(MODE_MERGE, 5, 5, 0, 0, 0, 1'b1, RES_SKIP));
        plan.push_back(beat_row(MODE_MERGE, 1023, 1023, -128, 0, 0, 1'b1, RES_SKIP));
        plan.push_back(beat_row(MODE_MERGE, 3, 3, -1, 0, 0, 1'b1, RES_SKIP));
        plan.push_back(beat_row(MODE_MERGE, 149, 149, 1, 0, 0, 1'b1,
                                '{1'b1, 1'b0, 1'b0, 17'd89999, 7'd1}));
        plan.push_back(beat_row(MODE_MERGE, 150, 0, 10, 0, 0, 1'b1, RES_OOB));
        plan.push_back(beat_row(MODE_MERGE, 1023, 1023, 127, 0, 0, 1'b1, RES_OOB));
        // merge fields ignored in read mode and read fields ignored in merge mode
        plan.push_back(beat_row(MODE_READ, 1023, 1023, 127, 150, 150, 1'b1,
                                '{1'b0, 1'b0, 1'b0, 17'd45150, 7'd127}));
        plan.push_back(beat_row(MODE_MERGE, 1, 2, 40, 511, 511, 1'b1,
                                '{1'b1, 1'b0, 1'b0, 17'd45751, 7'd40}));
        // pose at the grid corner; small negative world values truncate to cell 0
        plan.push_back(reg_row(CFG_POSE_X, 32'd0));
        plan.push_back(reg_row(CFG_POSE_Y, 32'd0));
        plan.push_back(beat_row(MODE_MERGE, 0, 0, 9, 0, 0, 1'b1,
                                '{1'b1, 1'b0, 1'b0, 17'd0, 7'd9}));
        plan.push_back(reg_row(CFG_ORIGIN_X, 32'hFFFF_4000));   // -0.75
        plan.push_back(beat_row(MODE_MERGE, 0, 0, 3, 0, 0, 1'b1,
                                '{1'b1, 1'b0, 1'b0, 17'd0, 7'd9}));
        plan.push_back(reg_row(CFG_ORIGIN_Y, 32'hFFFE_8000));   // -1.5, lands on -1.0
        plan.push_back(beat_row(MODE_MERGE, 0, 0, 3, 0, 0, 1'b1, RES_OOB));
        // quarter and half turns, trig extremes with junk in the upper half
        plan.push_back(reg_row(CFG_ORIGIN_X, 32'd0));
        plan.push_back(reg_row(CFG_ORIGIN_Y, 32'd0));
        plan.push_back(reg_row(CFG_POSE_X, 32'h0096_0000));
        plan.push_back(reg_row(CFG_POSE_Y, 32'h0096_0000));
        plan.push_back(reg_row(CFG_COS, 32'd0));
        plan.push_back(reg_row(CFG_SIN, 32'h0000_4000));
        plan.push_back(beat_row(MODE_MERGE, 10, 20, 50, 0, 0, 1'b0, '0));
        plan.push_back(reg_row(CFG_COS, 32'hABCD_C000));
        plan.push_back(reg_row(CFG_SIN, 32'd0));
        plan.push_back(beat_row(MODE_MERGE, 3, 4, 60, 0, 0, 1'b0, '0));
        plan.push_back(reg_row(CFG_COS, 32'd0));
        plan.push_back(reg_row(CFG_SIN, 32'hFFFF_C000));
        plan.push_back(beat_row(MODE_MERGE, 7, 7, 70, 0, 0, 1'b0, '0));
        // cell size extremes
        plan.push_back(reg_row(CFG_CELL_SIZE, 32'd0));
        plan.push_back(reg_row(CFG_COS, 32'h0000_4000));
        plan.push_back(reg_row(CFG_SIN, 32'd0));
        plan.push_back(beat_row(MODE_MERGE, 1023, 1023, 20, 0, 0, 1'b0, '0));
        plan.push_back(reg_row(CFG_CELL_SIZE, 32'hFFFF_FFFF));
        plan.push_back(beat_row(MODE_MERGE, 0, 0, 30, 0, 0, 1'b0, '0));
        plan.push_back(beat_row(MODE_MERGE, 1023, 1023, 30, 0, 0, 1'b0, '0));
        // origin and pose at opposite extremes nearly cancel
        plan.push_back(reg_row(CFG_CELL_SIZE, 32'd0));
        plan.push_back(reg_row(CFG_ORIGIN_X, 32'h8000_0000));
        plan.push_back(reg_row(CFG_ORIGIN_Y, 32'h7FFF_FFFF));
        plan.push_back(reg_row(CFG_POSE_X, 32'h7FFF_FFFF));
        plan.push_back(reg_row(CFG_POSE_Y, 32'h8000_0000));
        plan.push_back(reg_row(CFG_SPARE, 32'hFFFF_FFFF));
        plan.push_back(beat_row(MODE_MERGE, 0, 0, 1, 0, 0, 1'b0, '0));
        plan.push_back(beat_row(MODE_READ, 0, 0, 0, 150, 150, 1'b0, '0));

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[n]) begin
            if (plan[n].kind == ROW_REG) begin
                settle_block();
                write_reg(plan[n].reg_idx, plan[n].reg_data);
            end else begin
                send_item(plan[n].beat, plan[n].typed, plan[n].want);
                sender_gap();
            end
        end

        // Sender mostly busy, then receiver mostly busy, then both flat out.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct  = (ph == 0) ? 12 : (ph == 1) ? 88 : 0;
            recv_stall_pct = (ph == 0) ? 88 : (ph == 1) ? 12 : 0;
            for (int sub = 0; sub < 2; sub++) begin
                settle_block();
                load_setting(sub == 1);
                repeat (RANDOM_PHASE_BEATS) begin
                    it = random_beat();
                    send_item(it, 1'b0, '0);
                    sender_gap();
                    if ($urandom_range(0, 199) == 0)
                        settle_block();
                end
            end
        end

        settle_block();
        if (mismatches == 0)
            $display("costmap_rotate_merge_max_top test passed");
        else
            $display("costmap_rotate_merge_max_top test failed");
        $finish;
    end

endmodule

// File: files.f
hdl/cmrm_pkg.sv
hdl/cmrm_mac.sv
hdl/cmrm_grid.sv
hdl/costmap_rotate_merge_max_top.sv
sim/testbench.sv
